>>> hdl/ohns_pkg.sv
`timescale 1ns / 1ps

package ohns_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_OCTAVE_COUNT   = 2'd0;
	localparam logic [1:0] REG_BASE_FREQUENCY = 2'd1;
	localparam logic [1:0] REG_BASE_AMPLITUDE = 2'd2;

	// Reset values of the configuration registers
	localparam logic [4:0]  OCTAVE_COUNT_RST   = 5'd4;
	localparam logic [31:0] BASE_FREQUENCY_RST = 32'd65536;
	localparam logic [31:0] BASE_AMPLITUDE_RST = 32'd65536;

	// Hash constants
	localparam logic [31:0] HASH_MUL_Y  = 32'd57;
	localparam int unsigned HASH_SHIFT  = 13;
	localparam logic [31:0] HASH_K1     = 32'd60493;
	localparam logic [31:0] HASH_K2     = 32'd19990303;
	localparam logic [31:0] HASH_K3     = 32'd1376312589;
	localparam logic [31:0] HASH_MASK   = 32'h7fffffff;
	localparam logic [32:0] VALUE_ONE   = 33'h040000000;

	// Sum is Q.46; result is Q24.16
	localparam int unsigned ACC_FRAC = 30;

	// Operand selection for the shared multiplier
	typedef enum logic [2:0] {
		MS_SCALE_X,
		MS_SCALE_Y,
		MS_SQUARE,
		MS_KMUL,
		MS_NMUL,
		MS_WEIGHT
	} mul_sel_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE_X,
		ST_SCALE_Y,
		ST_LOAD_Y,
		ST_HASH,
		ST_SQUARE,
		ST_KMUL,
		ST_NMUL,
		ST_FOLD,
		ST_WEIGHT,
		ST_ACCUM,
		ST_FINISH
	} state_t;

	// Controls from the sequencer to the datapath
	typedef struct packed {
		mul_sel_t mul_sel;
		logic     mul_en;
		logic     load_item;
		logic     load_cx;
		logic     load_cy;
		logic     load_n1;
		logic     load_val;
		logic     accum;
		logic     finish;
	} ctrl_t;

endpackage

>>> hdl/octave_hash_noise_sum_top.sv
`timescale 1ns / 1ps
// After the start beat: scale X, scale Y, load Y, then hash to accum per octave (N =
// octaves, clamped), finish; done is registered. Busy is high meanwhile. Each octave
// takes four passes through the one shared 33x33 multiplier plus three steps.
// The result is shown for one cycle on done; the receiver cannot stall.
// Reset (arst_n low) returns to idle and loads the register reset values.

module octave_hash_noise_sum_top #(
	parameter int MAX_OCTAVES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic               cfg_we,
	input  logic        [1:0]  cfg_index,
	input  logic        [31:0] cfg_data,
	output logic               done,
	output logic signed [39:0] noise_sum
);

	import ohns_pkg::*;

	localparam int CW = $clog2(MAX_OCTAVES + 1);

	ctrl_t ctrl;

	logic [4:0]  octave_count_q;
	logic [31:0] base_frequency_q;
	logic [31:0] base_amplitude_q;

	logic               xneg_q;
	logic               yneg_q;
	logic [31:0]        xmag_q;
	logic [31:0]        ymag_q;
	logic [31:0]        amp_q;
	logic [CW-1:0]      rem_q;
	logic [63:0]        cx_q;
	logic [63:0]        cy_q;
	logic [31:0]        n1_q;
	logic signed [32:0] val_q;
	logic signed [63:0] acc_q;
	logic               done_q;
	logic signed [39:0] noise_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic [63:0]        prod_q;

	logic [5:0]  oct_req;
	logic [5:0]  oct_clamped;
	logic [31:0] ix;
	logic [31:0] iy;
	logic [31:0] n0;
	logic [31:0] n1;
	logic [31:0] hash;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q   <= OCTAVE_COUNT_RST;
			base_frequency_q <= BASE_FREQUENCY_RST;
			base_amplitude_q <= BASE_AMPLITUDE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OCTAVE_COUNT:   octave_count_q   <= cfg_data[4:0];
				REG_BASE_FREQUENCY: base_frequency_q <= cfg_data;
				REG_BASE_AMPLITUDE: base_amplitude_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the octave count
	assign oct_req     = {1'b0, octave_count_q};
	assign oct_clamped = (oct_req > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES) : oct_req;

	ohns_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.no_octaves  (rem_q == '0),
		.last_octave (rem_q == CW'(1)),
		.busy        (busy),
		.ctrl        (ctrl)
	);

	// Select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctrl.mul_sel)
			MS_SCALE_X: begin
				mul_a = {1'b0, xmag_q};
				mul_b = {1'b0, base_frequency_q};
			end
			MS_SCALE_Y: begin
				mul_a = {1'b0, ymag_q};
				mul_b = {1'b0, base_frequency_q};
			end
			MS_SQUARE: begin
				mul_a = {1'b0, n1_q};
				mul_b = {1'b0, n1_q};
			end
			MS_KMUL: begin
				mul_a = {1'b0, prod_q[31:0]};
				mul_b = {1'b0, HASH_K1};
			end
			MS_NMUL: begin
				mul_a = {1'b0, n1_q};
				mul_b = {1'b0, prod_q[31:0] + HASH_K2};
			end
			MS_WEIGHT: begin
				mul_a = val_q;
				mul_b = {1'b0, amp_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ohns_mul u_mul (
		.clk    (clk),
		.en     (ctrl.mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// Integer coordinates of this octave, then the first hash mix
	assign ix   = xneg_q ? (32'd0 - cx_q[63:32]) : cx_q[63:32];
	assign iy   = yneg_q ? (32'd0 - cy_q[63:32]) : cy_q[63:32];
	assign n0   = ix + iy * HASH_MUL_Y;
	assign n1   = (n0 << HASH_SHIFT) ^ n0;
	assign hash = (prod_q[31:0] + HASH_K3) & HASH_MASK;

	// Item datapath
	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			xneg_q <= point_x[31];
			yneg_q <= point_y[31];
			xmag_q <= point_x[31] ? (32'd0 - point_x) : point_x;
			ymag_q <= point_y[31] ? (32'd0 - point_y) : point_y;
			amp_q  <= base_amplitude_q;
			rem_q  <= CW'(oct_clamped);
			acc_q  <= '0;
		end
		if (ctrl.load_cx) begin
			cx_q <= prod_q;
		end
		if (ctrl.load_cy) begin
			cy_q <= prod_q;
		end
		if (ctrl.load_n1) begin
			n1_q <= n1;
		end
		// Map the hash to 1 - n/2^30 in Q2.30
		if (ctrl.load_val) begin
			val_q <= VALUE_ONE - {2'b00, hash[30:0]};
		end
		// Add the weighted value, then double coordinates and halve amplitude
		if (ctrl.accum) begin
			acc_q <= acc_q + $signed(prod_q);
			amp_q <= amp_q >> 1;
			cx_q  <= cx_q << 1;
			cy_q  <= cy_q << 1;
			rem_q <= rem_q - CW'(1);
		end
		// Floor shift to Q24.16; the sum always fits 40 bits, so no clamp fires
		if (ctrl.finish) begin
			noise_q <= 40'(acc_q >>> ACC_FRAC);
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.finish;
		end
	end

	assign done      = done_q;
	assign noise_sum = noise_q;

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_finish_once: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |=> !busy)
		else $error("sequencer did not return to idle after finish");
`endif

endmodule

>>> hdl/ohns_mul.sv
`timescale 1ns / 1ps

module ohns_mul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic        [63:0] prod_q
);

	logic signed [65:0] full;

	// Form the signed product; only the low 64 bits are ever needed
	assign full = a * b;

	// Register the product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= full[63:0];
		end
	end

endmodule

>>> hdl/ohns_seq.sv
`timescale 1ns / 1ps

module ohns_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           no_octaves,
	input  logic           last_octave,
	output logic           busy,
	output ohns_pkg::ctrl_t ctrl
);

	import ohns_pkg::*;

	state_t state_q;
	state_t state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the sequence and drive the datapath controls
	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		ctrl.mul_sel = MS_SCALE_X;
		busy         = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.load_item = 1'b1;
					state_d        = ST_SCALE_X;
				end
			end
			ST_SCALE_X: begin
				ctrl.mul_sel = MS_SCALE_X;
				ctrl.mul_en  = 1'b1;
				state_d      = ST_SCALE_Y;
			end
			ST_SCALE_Y: begin
				ctrl.mul_sel = MS_SCALE_Y;
				ctrl.mul_en  = 1'b1;
				ctrl.load_cx = 1'b1;
				state_d      = ST_LOAD_Y;
			end
			ST_LOAD_Y: begin
				ctrl.load_cy = 1'b1;
				state_d      = no_octaves ? ST_FINISH : ST_HASH;
			end
			ST_HASH: begin
				ctrl.load_n1 = 1'b1;
				state_d      = ST_SQUARE;
			end
			ST_SQUARE: begin
				ctrl.mul_sel = MS_SQUARE;
				ctrl.mul_en  = 1'b1;
				state_d      = ST_KMUL;
			end
			ST_KMUL: begin
				ctrl.mul_sel = MS_KMUL;
				ctrl.mul_en  = 1'b1;
				state_d      = ST_NMUL;
			end
			ST_NMUL: begin
				ctrl.mul_sel = MS_NMUL;
				ctrl.mul_en  = 1'b1;
				state_d      = ST_FOLD;
			end
			ST_FOLD: begin
				ctrl.load_val = 1'b1;
				state_d       = ST_WEIGHT;
			end
			ST_WEIGHT: begin
				ctrl.mul_sel = MS_WEIGHT;
				ctrl.mul_en  = 1'b1;
				state_d      = ST_ACCUM;
			end
			ST_ACCUM: begin
				ctrl.accum = 1'b1;
				state_d    = last_octave ? ST_FINISH : ST_HASH;
			end
			ST_FINISH: begin
				ctrl.finish = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> tb/sv/octave_hash_noise_sum_top_test.sv
`timescale 1ns / 1ps

module octave_hash_noise_sum_top_test;
	import ohns_pkg::*;

	localparam int MAX_OCTAVES = 16;
	// Index 3 decodes to no register; writes there must be dropped
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_LIMIT = 2000;
	localparam int TAIL_CYCLES = 5 + 7 * MAX_OCTAVES + 8;
	localparam int PHASE_POINTS = 615;
	localparam longint SUM_MAX = 64'sd549755813887;
	localparam longint SUM_MIN = -64'sd549755813888;

	// Expected noise sums, predicted from the register copy at each start beat
	class noise_sum_tracker;
		logic [4:0]         octaves;
		logic [31:0]        freq;
		logic [31:0]        amp;
		logic signed [39:0] expected_sums[$];
		int                 errors;
		int                 points;
		int                 results;

		function new();
			octaves = OCTAVE_COUNT_RST;
			freq    = BASE_FREQUENCY_RST;
			amp     = BASE_AMPLITUDE_RST;
			errors  = 0;
			points  = 0;
			results = 0;
		endfunction

		function void note_config(logic [1:0] idx, logic [31:0] data);
			case (idx)
				REG_OCTAVE_COUNT:   octaves = data[4:0];
				REG_BASE_FREQUENCY: freq    = data;
				REG_BASE_AMPLITUDE: amp     = data;
				default: ;
			endcase
		endfunction

		function logic [31:0] hash_lattice(logic [31:0] ix, logic [31:0] iy);
			logic [31:0] n;
			n = ix + iy * HASH_MUL_Y;
			n = (n << HASH_SHIFT) ^ n;
			n = (n * (n * n * HASH_K1 + HASH_K2) + HASH_K3) & HASH_MASK;
			return n;
		endfunction

		// Integer part of the scaled coordinate at one octave, wrapped to 32 bits
		function logic [31:0] lattice_coord(logic neg, logic [63:0] mag, int oct);
			logic [63:0] shifted;
			logic [31:0] v;
			shifted = mag >> (32 - oct);
			v = shifted[31:0];
			return neg ? 32'd0 - v : v;
		endfunction

		function logic signed [39:0] noise_octave_sum(logic [31:0] x, logic [31:0] y);
			logic        xneg;
			logic        yneg;
			logic [31:0] xmag;
			logic [31:0] ymag;
			logic [63:0] px;
			logic [63:0] py;
			logic [31:0] n;
			int          octs;
			longint      acc;
			longint      val;
			longint      wt;
			longint      res;
			xneg = x[31];
			yneg = y[31];
			xmag = xneg ? 32'd0 - x : x;
			ymag = yneg ? 32'd0 - y : y;
			px = {32'd0, xmag} * {32'd0, freq};
			py = {32'd0, ymag} * {32'd0, freq};
			octs = (int'(octaves) > MAX_OCTAVES) ? MAX_OCTAVES : int'(octaves);
			acc = 0;
			for (int i = 0; i < octs; i++) begin
				n = hash_lattice(lattice_coord(xneg, px, i), lattice_coord(yneg, py, i));
				val = 64'sd1073741824 - longint'({32'd0, n});
				wt = longint'({32'd0, amp >> i});
				acc += val * wt;
			end
			// Floor to Q24.16, then clamp to the 40-bit range
			res = acc >>> ACC_FRAC;
			if (res > SUM_MAX)
				res = SUM_MAX;
			if (res < SUM_MIN)
				res = SUM_MIN;
			return res[39:0];
		endfunction

		function void note_point(logic [31:0] x, logic [31:0] y);
			expected_sums.push_back(noise_octave_sum(x, y));
			points++;
		endfunction

		function void check_sum(logic signed [39:0] got);
			logic signed [39:0] want;
			if (expected_sums.size() == 0) begin
				errors++;
				$display("%0t: noise_sum %0d with no point waiting", $time, got);
				return;
			end
			want = expected_sums.pop_front();
			results++;
			if (got !== want) begin
				errors++;
				$display("%0t: noise_sum mismatch: expected %0d, actual %0d", $time, want, got);
			end
		endfunction

		function int pending();
			return expected_sums.size();
		endfunction

		function void flag_leftover();
			errors += expected_sums.size();
			$display("%0t: %0d noise_sum results never arrived", $time, expected_sums.size());
			expected_sums.delete();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic               cfg_we = 1'b0;
	logic        [1:0]  cfg_index = '0;
	logic        [31:0] cfg_data = '0;
	logic               done;
	logic signed [39:0] noise_sum;

	noise_sum_tracker board;
	int idle_pct = 8;
	int settings = 0;

	octave_hash_noise_sum_top #(
		.MAX_OCTAVES(MAX_OCTAVES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point_x(point_x),
		.point_y(point_y),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.noise_sum(noise_sum)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Check every result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_sum(noise_sum);
	end

	// Present one point, idle at random first, and hold it until the start beat
	task automatic send_point(logic [31:0] x, logic [31:0] y);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		point_x <= x;
		point_y <= y;
		do @(posedge clk); while (busy);
		board.note_point(x, y);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.note_config(idx, data);
	endtask

	task automatic apply_setting(logic [31:0] oct_word, logic [31:0] f, logic [31:0] a);
		write_reg(REG_OCTAVE_COUNT, oct_word);
		write_reg(REG_BASE_FREQUENCY, f);
		write_reg(REG_BASE_AMPLITUDE, a);
		if ($urandom_range(3) == 0)
			write_reg(REG_UNUSED, $urandom());
		cfg_we <= 1'b0;
		settings++;
	endtask

	// Drop start and hold until every predicted sum is back and the block is idle
	task automatic drain_results();
		int waited;
		waited = 0;
		start <= 1'b0;
		while ((board.pending() != 0 || busy) && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (board.pending() != 0)
			board.flag_leftover();
	endtask

	function automatic logic [31:0] pick_coord();
		logic [31:0] r;
		r = $urandom() >> $urandom_range(31);
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom_range(1) ? 32'd0 - r : r;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0001_0000;
			3, 4: return $urandom() >> $urandom_range(31);
			default: return $urandom();
		endcase
	endfunction

	// Mostly legal counts, a quarter above the clamp; junk in the unused bits
	function automatic logic [31:0] pick_octave_word();
		logic [31:0] word;
		word = $urandom();
		if ($urandom_range(3) == 0)
			word[4:0] = 5'($urandom_range(MAX_OCTAVES + 1, 31));
		else
			word[4:0] = 5'($urandom_range(0, MAX_OCTAVES));
		return word;
	endfunction

	initial begin
		int sent;
		int chunk;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes at the reset settings
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'hFFFF_FFFF, 32'h0000_0001);
		send_point(32'h0001_0000, 32'hFFFF_0000);
		drain_results();

		// Zero octaves: sum is zero
		apply_setting(32'd0, BASE_FREQUENCY_RST, BASE_AMPLITUDE_RST);
		send_point(32'h1234_5678, 32'h8765_4321);
		send_point(32'h8000_0000, 32'h7FFF_FFFF);
		drain_results();

		// Count above the clamp, full scale and weight: coordinates wrap
		apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'hFFFF_FFFF, 32'h0000_0001);
		drain_results();

		// Zero frequency, then zero amplitude, at the full count
		apply_setting(32'd16, 32'd0, 32'hFFFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_point(32'hDEAD_BEEF, 32'h0BAD_F00D);
		drain_results();
		apply_setting(32'd16, 32'h00FF_FFFF, 32'd0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_point(32'h0001_8000, 32'hFFFE_8000);
		drain_results();

		// Out-of-range index must leave the registers alone
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		cfg_we <= 1'b0;
		send_point(32'h0003_0000, 32'hFFFD_0000);
		send_point(32'h7FFF_FFFF, 32'h8000_0001);
		drain_results();

		// One octave at a large scale: integer part stays within 32 bits
		apply_setting(32'd1, 32'h0080_0000, 32'h0001_0000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_point(32'h4000_0000, 32'hC000_0000);
		send_point(32'h0000_0001, 32'hFFFF_FFFF);

		// Random settings in chunks; each boundary drains the block
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 8 : (phase == 1) ? 70 : 0;
			sent = 0;
			while (sent < PHASE_POINTS) begin
				drain_results();
				apply_setting(pick_octave_word(), pick_scale(), pick_scale());
				chunk = $urandom_range(20, 150);
				if (chunk > PHASE_POINTS - sent)
					chunk = PHASE_POINTS - sent;
				repeat (chunk) send_point(pick_coord(), pick_coord());
				sent += chunk;
			end
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d noise sums from %0d points over %0d register settings,",
			board.results, board.points, settings);
		$display("octave counts from none past the clamp, extreme scales, three idle mixes.");
		if (board.errors == 0) begin
			$display("** octave_hash_noise_sum_top: PASSED **");
		end else begin
			$display("** octave_hash_noise_sum_top: FAILED **");
		end
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("%0t: run timed out", $time);
		$display("** octave_hash_noise_sum_top: FAILED **");
		$finish;
	end

endmodule
